// File: src/gvip_pkg.sv
// ----------------------------------------------------------------------------
// gvip_pkg
// Shared widths, types, register codes, the sine table and helper functions
// for the grid vertex isometric projector.
// ----------------------------------------------------------------------------
package gvip_pkg;

	// Fixed-point format of the trigonometric values and the output clamp.
	localparam int TRIG_FRAC_BITS = 14;
	localparam int COORD_BITS     = 32;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 2;

	// Field widths.
	localparam int SCALE_W    = 10;
	localparam int DIM_W      = 11;
	localparam int ROT_DEG_W  = 9;
	localparam int ISO_DEG_W  = 7;
	localparam int GRID_W     = 10;
	localparam int ALT_W      = 16;
	localparam int COLOR_W    = 24;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int DEG_W      = 10;

	// Internal datapath widths, each derived from the stage before it.
	localparam int POS_W   = GRID_W + SCALE_W;
	localparam int CTR_W   = DIM_W + SCALE_W - 1;
	localparam int DELTA_W = POS_W + 2;
	localparam int PRODA_W = ALT_W + SCALE_W + 1;
	localparam int DEPTH_W = PRODA_W - 1;
	localparam int PROD_W  = DELTA_W + TRIG_W;
	localparam int ROTS_W  = PROD_W + 2;
	localparam int ROT_W   = ROTS_W - TRIG_FRAC_BITS;
	localparam int DIFF_W  = ROT_W + 1;
	localparam int ISO_W   = DIFF_W + TRIG_W;
	localparam int DSH_W   = DEPTH_W + TRIG_FRAC_BITS;
	localparam int ISOS_W  = ((ISO_W + 1 > DSH_W) ? ISO_W + 1 : DSH_W) + 1;
	localparam int FIN_W   = ISOS_W - TRIG_FRAC_BITS;
	localparam int SATB_W  = (FIN_W > COORD_BITS) ? FIN_W : COORD_BITS;
	localparam int SAT_W   = ((SATB_W > OUT_W) ? SATB_W : OUT_W) + 1;

	// Sine table covers one quadrant in whole degrees.
	localparam int QUARTER = 90;
	localparam int TAB_IDX_W = 7;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef logic        [POS_W-1:0]    pos_t;
	typedef logic        [CTR_W:0]      ctrw_t;
	typedef logic        [CTR_W-1:0]    ctr_t;
	typedef logic signed [DELTA_W-1:0]  delta_t;
	typedef logic signed [PRODA_W-1:0]  alt_prod_t;
	typedef logic signed [DEPTH_W-1:0]  depth_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ROTS_W-1:0]   rots_t;
	typedef logic signed [ROT_W-1:0]    rot_t;
	typedef logic signed [DIFF_W-1:0]   diff_t;
	typedef logic signed [ISO_W-1:0]    iso_t;
	typedef logic signed [ISOS_W-1:0]   isos_t;
	typedef logic signed [FIN_W-1:0]    fin_t;
	typedef logic signed [SAT_W-1:0]    sat_t;
	typedef logic signed [TRIG_W-1:0]   trig_t;
	typedef logic        [COLOR_W-1:0]  color_t;
	typedef logic        [DEG_W-1:0]    deg_t;
	typedef logic        [OUT_W-1:0]    out_t;
	typedef logic [QUARTER:0][TRIG_W-1:0] sin_tab_t;

	// Rounding offsets for truncation toward zero of a value over 2^F.
	localparam rots_t ROT_RND  = rots_t'((1 << TRIG_FRAC_BITS) - 1);
	localparam isos_t ISOS_RND = isos_t'((1 << TRIG_FRAC_BITS) - 1);

	// Clamp limits of a signed COORD_BITS value.
	localparam sat_t SAT_HI = {{(SAT_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
	localparam sat_t SAT_LO = ~SAT_HI;

	// Colours and the altitude threshold.
	localparam color_t COLOR_WHITE = 24'hFFFFFF;
	localparam color_t COLOR_HIGH  = 24'hFF2D00;
	localparam logic signed [ALT_W-1:0] HIGH_ALT = 16'sd8;

	// Register reset values.
	localparam logic [SCALE_W-1:0]   RST_SCALE   = 10'd1;
	localparam logic [DIM_W-1:0]     RST_WIDTH   = 11'd1;
	localparam logic [DIM_W-1:0]     RST_HEIGHT  = 11'd1;
	localparam logic [ROT_DEG_W-1:0] RST_ROT     = 9'd0;
	localparam logic                 RST_ISO     = 1'b1;
	localparam logic [ISO_DEG_W-1:0] RST_ISO_ANG = 7'd30;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE      = 3'd0,
		CFG_MAP_WIDTH  = 3'd1,
		CFG_MAP_HEIGHT = 3'd2,
		CFG_ROTATION   = 3'd3,
		CFG_ISO_ENABLE = 3'd4,
		CFG_ISO_ANGLE  = 3'd5
	} cfg_idx_t;

	// Current register contents.
	typedef struct packed {
		logic [SCALE_W-1:0]   scale;
		logic [DIM_W-1:0]     map_width;
		logic [DIM_W-1:0]     map_height;
		logic [ROT_DEG_W-1:0] rotation_deg;
		logic                 iso_enable;
		logic [ISO_DEG_W-1:0] iso_angle_deg;
	} cfg_t;

	// Payload handed from the scaling front end to the projection back end.
	typedef struct packed {
		ctr_t   cx;
		ctr_t   cy;
		prod_t  pxc;
		prod_t  pys;
		prod_t  pxs;
		prod_t  pyc;
		depth_t depth;
		logic   iso_enable;
		trig_t  ct;
		trig_t  st;
		color_t color;
	} mid_t;

	// Builds the quarter-wave sine table by an integer Taylor series in Q30,
	// rounded half up to TRIG_FRAC_BITS. Evaluated at elaboration only.
	function automatic sin_tab_t build_sin_tab();
		sin_tab_t    tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		for (int d = 0; d <= QUARTER; d++) begin
			x    = 64'(d) * PI_Q30 / 64'd180;
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (int k = 1; k <= 7; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if ((k & 1) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			sum = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
			tab[d] = sum[TRIG_W-1:0];
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

	// Sine of a whole-degree angle below 720, folded onto the first quadrant.
	function automatic trig_t sin_deg(input deg_t deg);
		deg_t  d;
		deg_t  idx;
		logic  neg;
		trig_t v;
		d = (deg >= deg_t'(360)) ? deg - deg_t'(360) : deg;
		if (d <= deg_t'(90)) begin
			idx = d;
			neg = 1'b0;
		end else if (d <= deg_t'(180)) begin
			idx = deg_t'(180) - d;
			neg = 1'b0;
		end else if (d <= deg_t'(270)) begin
			idx = d - deg_t'(180);
			neg = 1'b1;
		end else begin
			idx = deg_t'(360) - d;
			neg = 1'b1;
		end
		v = trig_t'(SIN_TAB[idx[TAB_IDX_W-1:0]]);
		return neg ? -v : v;
	endfunction

	// Clamps to signed COORD_BITS and gives the low output bits.
	function automatic out_t sat_coord(input sat_t v);
		sat_t r;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end else begin
			r = v;
		end
		return r[OUT_W-1:0];
	endfunction

endpackage

// File: src/grid_vertex_iso_projector_core.sv
// ----------------------------------------------------------------------------
// grid_vertex_iso_projector_core: height-map vertex scaling, rotation, iso view.
// A request enters the first of seven register stages at the edge that accepts
// it, and the seventh stage is the output register that holds the result.
// Throughput is one vertex per clock while out_stall is low, set by the seven-stage multiply/add line.
// Reset clears all stage valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module grid_vertex_iso_projector_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [gvip_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [gvip_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic        [gvip_pkg::GRID_W-1:0]      column,
	input  logic        [gvip_pkg::GRID_W-1:0]      row,
	input  logic signed [gvip_pkg::ALT_W-1:0]       altitude,
	input  logic                                   has_color,
	input  logic        [gvip_pkg::COLOR_W-1:0]     given_color,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [gvip_pkg::OUT_W-1:0]       screen_x,
	output logic signed [gvip_pkg::OUT_W-1:0]       screen_y,
	output logic signed [gvip_pkg::OUT_W-1:0]       depth,
	output logic        [gvip_pkg::COLOR_W-1:0]     color
);

	gvip_pkg::cfg_t cfg;
	gvip_pkg::mid_t mid;
	logic           mid_valid;
	logic           mid_ready;

	// Configuration registers.
	gvip_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Scaling and rotation products.
	gvip_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.column      (column),
		.row         (row),
		.altitude    (altitude),
		.has_color   (has_color),
		.given_color (given_color),
		.mid_valid   (mid_valid),
		.mid_ready   (mid_ready),
		.mid         (mid)
	);

	// Rotation sums, projection and output register.
	gvip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.depth     (depth),
		.color     (color)
	);

endmodule

// File: src/gvip_cfg.sv
// ----------------------------------------------------------------------------
// gvip_cfg
// Configuration register file. Every write request is taken at once; an
// index beyond the register list is ignored.
// ----------------------------------------------------------------------------
module gvip_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gvip_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gvip_pkg::CFG_DATA_W-1:0] cfg_data,
	output gvip_pkg::cfg_t                  cfg
);

	gvip_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register write, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale         <= gvip_pkg::RST_SCALE;
			cfg_q.map_width     <= gvip_pkg::RST_WIDTH;
			cfg_q.map_height    <= gvip_pkg::RST_HEIGHT;
			cfg_q.rotation_deg  <= gvip_pkg::RST_ROT;
			cfg_q.iso_enable    <= gvip_pkg::RST_ISO;
			cfg_q.iso_angle_deg <= gvip_pkg::RST_ISO_ANG;
		end else if (cfg_valid && cfg_ready) begin
			case (gvip_pkg::cfg_idx_t'(cfg_index))
				gvip_pkg::CFG_SCALE: begin
					cfg_q.scale <= cfg_data[gvip_pkg::SCALE_W-1:0];
				end
				gvip_pkg::CFG_MAP_WIDTH: begin
					cfg_q.map_width <= cfg_data[gvip_pkg::DIM_W-1:0];
				end
				gvip_pkg::CFG_MAP_HEIGHT: begin
					cfg_q.map_height <= cfg_data[gvip_pkg::DIM_W-1:0];
				end
				gvip_pkg::CFG_ROTATION: begin
					cfg_q.rotation_deg <= cfg_data[gvip_pkg::ROT_DEG_W-1:0];
				end
				gvip_pkg::CFG_ISO_ENABLE: begin
					cfg_q.iso_enable <= cfg_data[0];
				end
				gvip_pkg::CFG_ISO_ANGLE: begin
					cfg_q.iso_angle_deg <= cfg_data[gvip_pkg::ISO_DEG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: src/gvip_front.sv
// ----------------------------------------------------------------------------
// gvip_front
// Stages one and two: grid scaling, map centre, sine and cosine lookup,
// colour choice, then the offsets from the centre and the four rotation
// products together with the halved altitude.
// ----------------------------------------------------------------------------
module gvip_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gvip_pkg::cfg_t                        cfg,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic        [gvip_pkg::GRID_W-1:0]    column,
	input  logic        [gvip_pkg::GRID_W-1:0]    row,
	input  logic signed [gvip_pkg::ALT_W-1:0]     altitude,
	input  logic                                 has_color,
	input  logic        [gvip_pkg::COLOR_W-1:0]   given_color,
	output logic                                 mid_valid,
	input  logic                                 mid_ready,
	output gvip_pkg::mid_t                        mid
);

	logic en_s1;
	logic en_s2;
	logic v_s1;
	logic v_s2;

	gvip_pkg::pos_t      x_s1;
	gvip_pkg::pos_t      y_s1;
	gvip_pkg::alt_prod_t alt_prod_s1;
	gvip_pkg::ctr_t      cx_s1;
	gvip_pkg::ctr_t      cy_s1;
	gvip_pkg::trig_t     c_s1;
	gvip_pkg::trig_t     s_s1;
	gvip_pkg::trig_t     ct_s1;
	gvip_pkg::trig_t     st_s1;
	logic                iso_s1;
	gvip_pkg::color_t    color_s1;
	gvip_pkg::mid_t      mid_s2;

	logic [gvip_pkg::ROT_DEG_W-1:0] rot_mod;
	gvip_pkg::ctrw_t     wide_cx;
	gvip_pkg::ctrw_t     wide_cy;
	gvip_pkg::color_t    color_sel;
	gvip_pkg::delta_t    dx;
	gvip_pkg::delta_t    dy;
	gvip_pkg::alt_prod_t alt_adj;

	// A stage moves when it is empty or the next one moves.
	assign en_s2    = !v_s2 || mid_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	assign mid_valid = v_s2;
	assign mid       = mid_s2;

	// Stage one helpers: reduced rotation angle, centre products and colour.
	always_comb begin
		rot_mod = (cfg.rotation_deg >= gvip_pkg::ROT_DEG_W'(360)) ?
			cfg.rotation_deg - gvip_pkg::ROT_DEG_W'(360) : cfg.rotation_deg;
		wide_cx = gvip_pkg::ctrw_t'(cfg.map_width) * gvip_pkg::ctrw_t'(cfg.scale);
		wide_cy = gvip_pkg::ctrw_t'(cfg.map_height) * gvip_pkg::ctrw_t'(cfg.scale);
		if (has_color) begin
			color_sel = given_color;
		end else if (altitude > gvip_pkg::HIGH_ALT) begin
			color_sel = gvip_pkg::COLOR_HIGH;
		end else begin
			color_sel = gvip_pkg::COLOR_WHITE;
		end
	end

	// Stage two helpers: offsets from the centre and halving toward zero.
	always_comb begin
		dx      = gvip_pkg::delta_t'(x_s1) - gvip_pkg::delta_t'(cx_s1);
		dy      = gvip_pkg::delta_t'(y_s1) - gvip_pkg::delta_t'(cy_s1);
		alt_adj = alt_prod_s1 +
			gvip_pkg::alt_prod_t'({1'b0, alt_prod_s1[gvip_pkg::PRODA_W-1]});
	end

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage one data.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1        <= gvip_pkg::pos_t'(column) * gvip_pkg::pos_t'(cfg.scale);
			y_s1        <= gvip_pkg::pos_t'(row) * gvip_pkg::pos_t'(cfg.scale);
			alt_prod_s1 <= gvip_pkg::alt_prod_t'(altitude) *
				gvip_pkg::alt_prod_t'(cfg.scale);
			cx_s1       <= wide_cx[gvip_pkg::CTR_W:1];
			cy_s1       <= wide_cy[gvip_pkg::CTR_W:1];
			c_s1        <= gvip_pkg::sin_deg(gvip_pkg::deg_t'(rot_mod) +
				gvip_pkg::deg_t'(90));
			s_s1        <= gvip_pkg::sin_deg(gvip_pkg::deg_t'(rot_mod));
			ct_s1       <= gvip_pkg::sin_deg(gvip_pkg::deg_t'(cfg.iso_angle_deg) +
				gvip_pkg::deg_t'(90));
			st_s1       <= gvip_pkg::sin_deg(gvip_pkg::deg_t'(cfg.iso_angle_deg));
			iso_s1      <= cfg.iso_enable;
			color_s1    <= color_sel;
		end
	end

	// Stage two data: the four rotation products.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			mid_s2.cx         <= cx_s1;
			mid_s2.cy         <= cy_s1;
			mid_s2.pxc        <= gvip_pkg::prod_t'(dx) * gvip_pkg::prod_t'(c_s1);
			mid_s2.pys        <= gvip_pkg::prod_t'(dy) * gvip_pkg::prod_t'(s_s1);
			mid_s2.pxs        <= gvip_pkg::prod_t'(dx) * gvip_pkg::prod_t'(s_s1);
			mid_s2.pyc        <= gvip_pkg::prod_t'(dy) * gvip_pkg::prod_t'(c_s1);
			mid_s2.depth      <= alt_adj[gvip_pkg::PRODA_W-1:1];
			mid_s2.iso_enable <= iso_s1;
			mid_s2.ct         <= ct_s1;
			mid_s2.st         <= st_s1;
			mid_s2.color      <= color_s1;
		end
	end

endmodule

// File: src/gvip_back.sv
// ----------------------------------------------------------------------------
// gvip_back
// Stages three to seven: rotation sums, truncation of the rotated point,
// isometric products, depth subtraction, then final truncation, mode
// select and clamping into the output register.
// ----------------------------------------------------------------------------
module gvip_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                mid_valid,
	output logic                                mid_ready,
	input  gvip_pkg::mid_t                       mid,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [gvip_pkg::OUT_W-1:0]    screen_x,
	output logic signed [gvip_pkg::OUT_W-1:0]    screen_y,
	output logic signed [gvip_pkg::OUT_W-1:0]    depth,
	output logic        [gvip_pkg::COLOR_W-1:0]  color
);

	localparam int F = gvip_pkg::TRIG_FRAC_BITS;

	logic en_s3;
	logic en_s4;
	logic en_s5;
	logic en_s6;
	logic en_s7;
	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic v_s6;
	logic v_s7;

	// Stage three.
	gvip_pkg::rots_t  sum_x_s3;
	gvip_pkg::rots_t  sum_y_s3;
	gvip_pkg::depth_t depth_s3;
	logic             iso_s3;
	gvip_pkg::trig_t  ct_s3;
	gvip_pkg::trig_t  st_s3;
	gvip_pkg::color_t color_s3;
	// Stage four.
	gvip_pkg::rot_t   rx_s4;
	gvip_pkg::rot_t   ry_s4;
	gvip_pkg::depth_t depth_s4;
	logic             iso_s4;
	gvip_pkg::trig_t  ct_s4;
	gvip_pkg::trig_t  st_s4;
	gvip_pkg::color_t color_s4;
	// Stage five.
	gvip_pkg::iso_t   pd_s5;
	gvip_pkg::iso_t   ps_s5;
	gvip_pkg::rot_t   rx_s5;
	gvip_pkg::rot_t   ry_s5;
	gvip_pkg::depth_t depth_s5;
	logic             iso_s5;
	gvip_pkg::color_t color_s5;
	// Stage six.
	gvip_pkg::isos_t  sxw_s6;
	gvip_pkg::isos_t  syw_s6;
	gvip_pkg::rot_t   rx_s6;
	gvip_pkg::rot_t   ry_s6;
	gvip_pkg::depth_t depth_s6;
	logic             iso_s6;
	gvip_pkg::color_t color_s6;
	// Stage seven, the output register.
	gvip_pkg::out_t   screen_x_s7;
	gvip_pkg::out_t   screen_y_s7;
	gvip_pkg::out_t   depth_s7;
	gvip_pkg::color_t color_s7;

	gvip_pkg::rots_t  adj_x;
	gvip_pkg::rots_t  adj_y;
	gvip_pkg::diff_t  diff;
	gvip_pkg::diff_t  summ;
	gvip_pkg::isos_t  adj_sx;
	gvip_pkg::isos_t  adj_sy;
	gvip_pkg::fin_t   sel_x;
	gvip_pkg::fin_t   sel_y;

	// A stage moves when it is empty or the next one moves.
	assign en_s7     = !v_s7 || !out_stall;
	assign en_s6     = !v_s6 || en_s7;
	assign en_s5     = !v_s5 || en_s6;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign mid_ready = en_s3;

	assign out_valid = v_s7;
	assign screen_x  = screen_x_s7;
	assign screen_y  = screen_y_s7;
	assign depth     = depth_s7;
	assign color     = color_s7;

	// Truncation toward zero of the rotation sums.
	always_comb begin
		adj_x = sum_x_s3 + (sum_x_s3[gvip_pkg::ROTS_W-1] ? gvip_pkg::ROT_RND :
			gvip_pkg::rots_t'(0));
		adj_y = sum_y_s3 + (sum_y_s3[gvip_pkg::ROTS_W-1] ? gvip_pkg::ROT_RND :
			gvip_pkg::rots_t'(0));
	end

	// Difference and sum feeding the isometric products.
	always_comb begin
		diff = gvip_pkg::diff_t'(rx_s4) - gvip_pkg::diff_t'(ry_s4);
		summ = gvip_pkg::diff_t'(rx_s4) + gvip_pkg::diff_t'(ry_s4);
	end

	// Final truncation and mode select.
	always_comb begin
		adj_sx = sxw_s6 + (sxw_s6[gvip_pkg::ISOS_W-1] ? gvip_pkg::ISOS_RND :
			gvip_pkg::isos_t'(0));
		adj_sy = syw_s6 + (syw_s6[gvip_pkg::ISOS_W-1] ? gvip_pkg::ISOS_RND :
			gvip_pkg::isos_t'(0));
		if (iso_s6) begin
			sel_x = adj_sx[gvip_pkg::ISOS_W-1:F];
			sel_y = adj_sy[gvip_pkg::ISOS_W-1:F];
		end else begin
			sel_x = gvip_pkg::fin_t'(rx_s6);
			sel_y = gvip_pkg::fin_t'(ry_s6);
		end
	end

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= mid_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
			if (en_s7) begin
				v_s7 <= v_s6;
			end
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			sum_x_s3 <= (gvip_pkg::rots_t'(mid.cx) <<< F) +
				gvip_pkg::rots_t'(mid.pxc) - gvip_pkg::rots_t'(mid.pys);
			sum_y_s3 <= (gvip_pkg::rots_t'(mid.cy) <<< F) +
				gvip_pkg::rots_t'(mid.pxs) + gvip_pkg::rots_t'(mid.pyc);
			depth_s3 <= mid.depth;
			iso_s3   <= mid.iso_enable;
			ct_s3    <= mid.ct;
			st_s3    <= mid.st;
			color_s3 <= mid.color;
		end
		if (en_s4) begin
			rx_s4    <= adj_x[gvip_pkg::ROTS_W-1:F];
			ry_s4    <= adj_y[gvip_pkg::ROTS_W-1:F];
			depth_s4 <= depth_s3;
			iso_s4   <= iso_s3;
			ct_s4    <= ct_s3;
			st_s4    <= st_s3;
			color_s4 <= color_s3;
		end
		if (en_s5) begin
			pd_s5    <= gvip_pkg::iso_t'(diff) * gvip_pkg::iso_t'(ct_s4);
			ps_s5    <= gvip_pkg::iso_t'(summ) * gvip_pkg::iso_t'(st_s4);
			rx_s5    <= rx_s4;
			ry_s5    <= ry_s4;
			depth_s5 <= depth_s4;
			iso_s5   <= iso_s4;
			color_s5 <= color_s4;
		end
		if (en_s6) begin
			sxw_s6   <= gvip_pkg::isos_t'(pd_s5);
			syw_s6   <= gvip_pkg::isos_t'(ps_s5) - (gvip_pkg::isos_t'(depth_s5) <<< F);
			rx_s6    <= rx_s5;
			ry_s6    <= ry_s5;
			depth_s6 <= depth_s5;
			iso_s6   <= iso_s5;
			color_s6 <= color_s5;
		end
		if (en_s7) begin
			screen_x_s7 <= gvip_pkg::sat_coord(gvip_pkg::sat_t'(sel_x));
			screen_y_s7 <= gvip_pkg::sat_coord(gvip_pkg::sat_t'(sel_y));
			depth_s7    <= gvip_pkg::sat_coord(gvip_pkg::sat_t'(depth_s6));
			color_s7    <= color_s6;
		end
	end

endmodule

// File: src/gvip_checker.sv
// ----------------------------------------------------------------------------
// gvip_checker
// Port-level checks of the projector: held results under stall, arrival of
// a result after an accepted request and colour pass-through. Bound to the top level.
// ----------------------------------------------------------------------------
module gvip_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   cfg_valid,
	input logic                                   cfg_ready,
	input logic        [gvip_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic        [gvip_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic        [gvip_pkg::GRID_W-1:0]      column,
	input logic        [gvip_pkg::GRID_W-1:0]      row,
	input logic signed [gvip_pkg::ALT_W-1:0]       altitude,
	input logic                                   has_color,
	input logic        [gvip_pkg::COLOR_W-1:0]     given_color,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic signed [gvip_pkg::OUT_W-1:0]       screen_x,
	input logic signed [gvip_pkg::OUT_W-1:0]       screen_y,
	input logic signed [gvip_pkg::OUT_W-1:0]       depth,
	input logic        [gvip_pkg::COLOR_W-1:0]     color
);

	logic [3:0] age_q;
	logic       settled;
	logic       unused_ok;

	// Counts clock edges since reset so that history checks start clean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= 4'd0;
		end else if (age_q != 4'd8) begin
			age_q <= age_q + 4'd1;
		end
	end

	assign settled   = (age_q == 4'd8);
	assign unused_ok = cfg_valid | cfg_ready | (|cfg_index) | (|cfg_data) |
		(|column) | (|row) | (|altitude);

	// A stalled result stays valid.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its fields.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(screen_x) && $stable(screen_y) &&
		$stable(depth) && $stable(color))
		else $error("result changed while stalled");

	// With no stall in between, an accepted request shows as a valid result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		settled && $past(in_valid && !in_stall, 7) &&
		!$past(out_stall, 1) && !$past(out_stall, 2) && !$past(out_stall, 3) &&
		!$past(out_stall, 4) && !$past(out_stall, 5) && !$past(out_stall, 6)
		|-> out_valid)
		else $error("result missing after pipeline latency");

	// An explicit colour passes through unchanged.
	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		settled && $past(in_valid && !in_stall && has_color, 7) &&
		!$past(out_stall, 1) && !$past(out_stall, 2) && !$past(out_stall, 3) &&
		!$past(out_stall, 4) && !$past(out_stall, 5) && !$past(out_stall, 6)
		|-> color == $past(given_color, 7))
		else $error("explicit colour not passed through");

endmodule

bind grid_vertex_iso_projector_core gvip_checker u_gvip_checker (.*);
